[design/sab_pkg.sv]
// shared types and constants for the suffix automaton builder
package sab_pkg;

  localparam int MAX_CHARS = 65536;
  localparam int ALPHABET  = 12;
  localparam int IDX_W     = 17;
  localparam int SYM_W     = 4;
  localparam int NODES     = 1 << IDX_W;
  localparam int TRANS_D   = NODES << SYM_W;
  localparam logic [IDX_W-1:0] NONE_IDX = '0;
  localparam logic [IDX_W-1:0] ROOT_IDX = IDX_W'(1);

  typedef struct packed {
    logic             restart;
    logic [SYM_W-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] new_state;
    logic [IDX_W-1:0] new_length;
    logic [IDX_W-1:0] new_link;
    logic             clone_made;
    logic [IDX_W-1:0] clone_state;
    logic [IDX_W-1:0] state_count;
    logic             overflow;
  } out_t;

endpackage

[design/sab_ram.sv]
// generic simple dual-port ram with registered read
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/suffix_automaton_builder.sv]
// suffix automaton builder top level: sequencer over length, link and transition rams
// Each request appends one symbol to a suffix automaton kept in three rams (length, suffix
// link, transition rows of 16 slots addressed by {state, symbol}). A request that makes no
// clone walks suffix links until it passes the root or reaches a state that already has
// the transition; its pace is set by the single read port of the transition ram and the
// row clear for every new state. A clone adds a row copy, a step per redirected transition
// and the end of the redirect walk. A request that is ignored (symbol out of range or
// capacity reached) gets a result with no new state. After reset, and on restart, the root
// row is cleared before work goes on. The block takes one request at a time and holds the
// result in an output register until it is taken.
module suffix_automaton_builder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sab_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sab_pkg::out_t out_data
);

  localparam int IW = sab_pkg::IDX_W;
  localparam int SW = sab_pkg::SYM_W;
  localparam int TAW = IW + SW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_START = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_LEN1  = 13'b0000000001000,
    S_ZERO  = 13'b0000000010000,
    S_WALK  = 13'b0000000100000,
    S_WCHK  = 13'b0000001000000,
    S_QCHK  = 13'b0000010000000,
    S_COPY  = 13'b0000100000000,
    S_REDIR = 13'b0001000000000,
    S_RCHK  = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic restart_r, restart_nxt;
  logic [SW-1:0] sym_r, sym_nxt, k_r, k_nxt;
  logic [IW-1:0] last_r, last_nxt, used_r, used_nxt, taken_r, taken_nxt;
  logic [IW-1:0] cur_r, cur_nxt, p_r, p_nxt, q_r, q_nxt, cl_r, cl_nxt, row_r, row_nxt;
  logic [IW-1:0] plen_r, plen_nxt, curlen_r, curlen_nxt, curlink_r, curlink_nxt;
  logic cloned_r, cloned_nxt, out_valid_r, out_valid_nxt;
  sab_pkg::out_t out_r, out_nxt;

  logic len_we, link_we, tr_we;
  logic [IW-1:0] len_wa, len_wd, len_ra, len_rd, link_wa, link_wd, link_ra, link_rd;
  logic [TAW-1:0] tr_wa, tr_ra;
  logic [IW-1:0] tr_wd, tr_rd;

  sab_ram #(.WIDTH(IW), .DEPTH(sab_pkg::NODES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra), .rdata(len_rd)
  );
  sab_ram #(.WIDTH(IW), .DEPTH(sab_pkg::NODES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(link_ra),
    .rdata(link_rd)
  );
  sab_ram #(.WIDTH(IW), .DEPTH(sab_pkg::TRANS_D)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; restart_nxt = restart_r; sym_nxt = sym_r;
    k_nxt = k_r; last_nxt = last_r; used_nxt = used_r; taken_nxt = taken_r;
    cur_nxt = cur_r; p_nxt = p_r; q_nxt = q_r; cl_nxt = cl_r; row_nxt = row_r;
    plen_nxt = plen_r; curlen_nxt = curlen_r; curlink_nxt = curlink_r;
    cloned_nxt = cloned_r; out_valid_nxt = out_valid_r; out_nxt = out_r;
    len_we = 1'b0; len_wa = row_r; len_wd = '0; len_ra = last_r;
    link_we = 1'b0; link_wa = cur_r; link_wd = '0; link_ra = p_r;
    tr_we = 1'b0; tr_wa = {row_r, k_r}; tr_wd = '0; tr_ra = {p_r, sym_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          restart_nxt = in_data.restart;
          sym_nxt = in_data.symbol;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (restart_r) begin
          last_nxt = sab_pkg::ROOT_IDX;
          used_nxt = IW'(1);
          taken_nxt = '0;
          row_nxt = sab_pkg::ROOT_IDX;
          k_nxt = '0;
          ret_nxt = S_CHK;
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        out_nxt = '0;
        out_nxt.state_count = used_r;
        if (32'(taken_r) >= sab_pkg::MAX_CHARS) begin
          out_nxt.overflow = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (32'(sym_r) >= sab_pkg::ALPHABET) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cur_nxt = used_r + IW'(1);
          used_nxt = used_r + IW'(1);
          p_nxt = last_r;
          cloned_nxt = 1'b0;
          cl_nxt = '0;
          state_nxt = S_LEN1;
        end
      end
      S_LEN1: begin
        curlen_nxt = len_rd + IW'(1);
        len_we = 1'b1;
        len_wa = cur_r;
        len_wd = len_rd + IW'(1);
        row_nxt = cur_r;
        k_nxt = '0;
        ret_nxt = S_WALK;
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        tr_we = 1'b1;
        if (row_r == sab_pkg::ROOT_IDX && k_r == '0) begin
          len_we = 1'b1;
          link_we = 1'b1;
          link_wa = row_r;
        end
        k_nxt = k_r + SW'(1);
        if (32'(k_r) == sab_pkg::ALPHABET - 1) begin
          state_nxt = ret_r;
        end
      end
      S_WALK: begin
        len_ra = p_r;
        if (p_r == sab_pkg::NONE_IDX) begin
          link_we = 1'b1;
          link_wd = sab_pkg::ROOT_IDX;
          curlink_nxt = sab_pkg::ROOT_IDX;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (tr_rd == sab_pkg::NONE_IDX) begin
          tr_we = 1'b1;
          tr_wa = {p_r, sym_r};
          tr_wd = cur_r;
          p_nxt = link_rd;
          state_nxt = S_WALK;
        end else begin
          q_nxt = tr_rd;
          plen_nxt = len_rd;
          len_ra = tr_rd;
          link_ra = tr_rd;
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (plen_r + IW'(1) == len_rd) begin
          link_we = 1'b1;
          link_wd = q_r;
          curlink_nxt = q_r;
          state_nxt = S_FIN;
        end else begin
          cl_nxt = used_r + IW'(1);
          used_nxt = used_r + IW'(1);
          cloned_nxt = 1'b1;
          len_we = 1'b1;
          len_wa = used_r + IW'(1);
          len_wd = plen_r + IW'(1);
          link_we = 1'b1;
          link_wa = used_r + IW'(1);
          link_wd = link_rd;
          k_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        tr_ra = {q_r, k_r};
        if (k_r != '0) begin
          tr_we = 1'b1;
          tr_wa = {cl_r, k_r - SW'(1)};
          tr_wd = tr_rd;
        end
        k_nxt = k_r + SW'(1);
        if (32'(k_r) == sab_pkg::ALPHABET) begin
          state_nxt = S_REDIR;
        end
      end
      S_REDIR: begin
        if (p_r == sab_pkg::NONE_IDX) begin
          link_we = 1'b1;
          link_wa = q_r;
          link_wd = cl_r;
          state_nxt = S_RCHK;
          k_nxt = '1;
        end else begin
          k_nxt = '0;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (k_r == '1) begin
          link_we = 1'b1;
          link_wd = cl_r;
          curlink_nxt = cl_r;
          state_nxt = S_FIN;
        end else if (tr_rd == q_r) begin
          tr_we = 1'b1;
          tr_wa = {p_r, sym_r};
          tr_wd = cl_r;
          p_nxt = link_rd;
          state_nxt = S_REDIR;
        end else begin
          p_nxt = sab_pkg::NONE_IDX;
          state_nxt = S_REDIR;
        end
      end
      S_FIN: begin
        out_nxt.new_state = cur_r;
        out_nxt.new_length = curlen_r;
        out_nxt.new_link = curlink_r;
        out_nxt.clone_made = cloned_r;
        out_nxt.clone_state = cl_r;
        out_nxt.state_count = used_r;
        out_nxt.overflow = 1'b0;
        out_valid_nxt = 1'b1;
        last_nxt = cur_r;
        taken_nxt = taken_r + IW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ZERO;
      ret_r <= S_IDLE;
      row_r <= sab_pkg::ROOT_IDX;
      k_r <= '0;
      last_r <= sab_pkg::ROOT_IDX;
      used_r <= IW'(1);
      taken_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      row_r <= row_nxt;
      k_r <= k_nxt;
      last_r <= last_nxt;
      used_r <= used_nxt;
      taken_r <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
    restart_r <= restart_nxt; sym_r <= sym_nxt; cur_r <= cur_nxt; p_r <= p_nxt;
    q_r <= q_nxt; cl_r <= cl_nxt; plen_r <= plen_nxt; curlen_r <= curlen_nxt;
    curlink_r <= curlink_nxt; cloned_r <= cloned_nxt; out_r <= out_nxt;
  end

`ifndef SYNTH
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result shown outside output state");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r)) else $error("ready while result pending");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.state_count != '0) else $error("state count zero");
`endif

endmodule
